[hw/rtl/crc32_wide_stream_engine_unit_defines.svh]
// Assertion macros for the CRC-32 wide stream engine RTL, included by crc32w_skid.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef CRC32_WIDE_STREAM_ENGINE_UNIT_DEFINES_SVH
`define CRC32_WIDE_STREAM_ENGINE_UNIT_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define CRC32W_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause.
`define CRC32W_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/crc32w_pkg.sv]
// Types, constants and GF(2) advance tables for the CRC-32 wide stream engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package crc32w_pkg;

	localparam int MAX_BYTES = 16;
	localparam int CRC_W     = 32;
	localparam int COUNT_W   = 5;
	localparam int CFG_IDX_W = 2;
	localparam int S_TDATA_W = 136;

	typedef logic [CRC_W-1:0]   crc_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam crc_t CRC_POLY = 32'hEDB88320;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT = 2'd1;

	// Control that travels with the merged lane sum
	typedef struct packed {
		count_t count;
		logic   first;
		logic   last;
	} s1_ctrl_t;

	// One result item
	typedef struct packed {
		crc_t crc_value;
		logic final_flag;
	} out_item_t;

	// Column i of entry m: the register after folding m zero bytes into 1 << i
	typedef logic [MAX_BYTES:0][CRC_W-1:0][CRC_W-1:0] adv_tbl_t;

	// Fold one zero byte, least significant bit first
	function automatic crc_t step_zero_byte(input crc_t c);
		crc_t v;
		v = c;
		for (int b = 0; b < 8; b++) begin
			v = (v >> 1) ^ (v[0] ? CRC_POLY : '0);
		end
		return v;
	endfunction

	function automatic adv_tbl_t build_adv();
		adv_tbl_t t;
		crc_t     v;
		for (int i = 0; i < CRC_W; i++) begin
			v = crc_t'(1) << i;
			for (int m = 0; m <= MAX_BYTES; m++) begin
				t[m][i] = v;
				v = step_zero_byte(v);
			end
		end
		return t;
	endfunction

	localparam adv_tbl_t ADV_TABLE = build_adv();

	// Advance a register value by a number of zero bytes (linear map)
	function automatic crc_t apply_adv(input count_t steps, input crc_t c);
		crc_t acc;
		acc = '0;
		for (int i = 0; i < CRC_W; i++) begin
			if (c[i]) begin
				acc = acc ^ ADV_TABLE[steps][i];
			end
		end
		return acc;
	endfunction

endpackage

[hw/rtl/crc32w_lane.sv]
// One byte lane: contribution of a message byte to the CRC at the end of the item.
// Depends on crc32w_pkg for the advance tables.
`timescale 1ns / 1ps

module crc32w_lane
	import crc32w_pkg::*;
#(
	parameter int LANE = 0
) (
	input  logic [7:0] lane_byte,
	input  count_t     count,
	output crc_t       contrib
);

	count_t steps;

	// A byte at position LANE is followed by count - LANE - 1 bytes, plus its own fold
	assign steps = count - COUNT_W'(LANE);

	// Drop lanes past the valid byte count
	assign contrib = (count > COUNT_W'(LANE)) ? apply_adv(steps, {24'd0, lane_byte}) : '0;

endmodule

[hw/rtl/crc32w_fold.sv]
// Running CRC register: advances the held value over the item's bytes and adds lane sum.
// Depends on crc32w_pkg for types and the advance tables.
`timescale 1ns / 1ps

module crc32w_fold
	import crc32w_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  s1_ctrl_t  ctrl,
	input  crc_t      data_part,
	input  crc_t      seed,
	input  logic      invert,
	output out_item_t result
);

	crc_t crc_q;
	crc_t start;
	crc_t next_crc;

	// Reload from the seed on the first item of a message
	assign start = ctrl.first ? (invert ? ~seed : seed) : crc_q;

	// Shift the old value past all bytes, then add the bytes themselves
	assign next_crc = apply_adv(ctrl.count, start) ^ data_part;

	assign result.crc_value  = invert ? ~next_crc : next_crc;
	assign result.final_flag = ctrl.last;

	// Hold the running value between items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (adv) begin
			crc_q <= next_crc;
		end
	end

endmodule

[hw/rtl/crc32w_skid.sv]
// Output register with a skid entry, so the upstream ready comes from a flop.
// Depends on crc32w_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "crc32_wide_stream_engine_unit_defines.svh"

module crc32w_skid
	import crc32w_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t in_item,
	output logic      in_ready,
	output logic      out_valid,
	output out_item_t out_item,
	input  logic      out_ready
);

	logic      out_v_q;
	logic      skid_v_q;
	out_item_t main_q;
	out_item_t skid_q;
	logic      pop;

	assign pop       = out_v_q && out_ready;
	assign in_ready  = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_item  = main_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			out_v_q <= 1'b1;
			if (out_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	// Payload: advance from skid, take a new item, or park it in the skid entry
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (!out_v_q || pop) begin
				main_q <= in_item;
			end else begin
				skid_q <= in_item;
			end
		end
	end

	`CRC32W_ASSERT_NOW(a_skid_needs_main, skid_v_q, out_v_q, "skid item held without main item")
	`CRC32W_ASSERT_NEXT(a_stall_fills_skid, push && out_v_q && !out_ready, skid_v_q, "stalled item lost")
	`CRC32W_ASSERT_NEXT(a_skid_drains, pop && skid_v_q, out_v_q && !skid_v_q, "skid item not moved up")

endmodule

[hw/rtl/crc32_wide_stream_engine_unit.sv]
// Reflected CRC-32 (polynomial 0xEDB88320) over a byte stream, up to 16 bytes per item.
// The block takes one item per clock unless the output stalls and returns one result item
// for each, registered in stage 1 and then in the output register. The rate is set by the
// running-CRC update in the fold stage; the byte lanes and their XOR merge sit in the stage
// before it. cfg index 0 is the seed, index 1 the invert mode (reset 1); a first item
// reloads from the seed. Depends on crc32w_pkg, crc32w_lane, crc32w_fold and crc32w_skid.
`timescale 1ns / 1ps

module crc32_wide_stream_engine_unit
	import crc32w_pkg::*;
#(
	parameter int BYTES_PER_ITEM = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CRC_W-1:0]     cfg_data,
	// Input items
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // data_low[63:0], data_high[127:64], byte_count[132:128]
	input  logic [0:0]           s_tuser,   // first_item
	input  logic                 s_tlast,   // last_item
	// Result items
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [CRC_W-1:0]     m_tdata,   // crc_value
	output logic                 m_tlast    // final_flag
);

	crc_t      seed_q;
	logic      invert_q;
	count_t    byte_count;
	count_t    count_sat;
	crc_t      lane_contrib [BYTES_PER_ITEM];
	crc_t      merged;
	logic      s1_v_q;
	s1_ctrl_t  ctrl_s1;
	crc_t      data_s1;
	logic      out_ready;
	logic      push;
	logic      accept;
	out_item_t fold_result;
	out_item_t out_item;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= '0;
			invert_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SEED:   seed_q   <= cfg_data;
				REG_INVERT: invert_q <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// Saturate the byte count to the lane count
	assign byte_count = s_tdata[2*64 +: COUNT_W];
	assign count_sat  = (byte_count > COUNT_W'(BYTES_PER_ITEM)) ?
		COUNT_W'(BYTES_PER_ITEM) : byte_count;

	// Byte lanes; data_high follows data_low, so byte j sits at bits 8j+7:8j
	for (genvar j = 0; j < BYTES_PER_ITEM; j++) begin : g_lane
		crc32w_lane #(
			.LANE(j)
		) u_lane (
			.lane_byte(s_tdata[8*j +: 8]),
			.count    (count_sat),
			.contrib  (lane_contrib[j])
		);
	end

	// Merge the lane contributions
	always_comb begin
		merged = '0;
		for (int j = 0; j < BYTES_PER_ITEM; j++) begin
			merged = merged ^ lane_contrib[j];
		end
	end

	// Stage 1 handshake
	assign push     = s1_v_q && out_ready;
	assign s_tready = !s1_v_q || out_ready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (s_tready) begin
			s1_v_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1       <= merged;
			ctrl_s1.count <= count_sat;
			ctrl_s1.first <= s_tuser[0];
			ctrl_s1.last  <= s_tlast;
		end
	end

	crc32w_fold u_fold (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (push),
		.ctrl     (ctrl_s1),
		.data_part(data_s1),
		.seed     (seed_q),
		.invert   (invert_q),
		.result   (fold_result)
	);

	crc32w_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_item  (fold_result),
		.in_ready (out_ready),
		.out_valid(m_tvalid),
		.out_item (out_item),
		.out_ready(m_tready)
	);

	assign m_tdata = out_item.crc_value;
	assign m_tlast = out_item.final_flag;

endmodule
